// ----- sv/mcsr_pkg.sv -----
// Package for the machine-mode CSR file: beat types, CSR numbers,
// write masks, status codes and the misa reset value.
// No dependencies.
package mcsr_pkg;

	localparam int XLEN = 64;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_UNDEF    = 2'd1;
	localparam logic [1:0] STATUS_READONLY = 2'd2;

	// CSR numbers
	localparam logic [11:0] CSR_MSTATUS   = 12'h300;
	localparam logic [11:0] CSR_MISA      = 12'h301;
	localparam logic [11:0] CSR_MIE       = 12'h304;
	localparam logic [11:0] CSR_MTVEC     = 12'h305;
	localparam logic [11:0] CSR_MSCRATCH  = 12'h340;
	localparam logic [11:0] CSR_MEPC      = 12'h341;
	localparam logic [11:0] CSR_MCAUSE    = 12'h342;
	localparam logic [11:0] CSR_MTVAL     = 12'h343;
	localparam logic [11:0] CSR_MIP       = 12'h344;
	localparam logic [11:0] CSR_MVENDORID = 12'hF11;
	localparam logic [11:0] CSR_MARCHID   = 12'hF12;
	localparam logic [11:0] CSR_MIMPID    = 12'hF13;
	localparam logic [11:0] CSR_MHARTID   = 12'hF14;

	// legalization masks and fixed values
	localparam logic [12:0]     MSTATUS_MASK   = 13'h1888;
	localparam logic [XLEN-1:0] MSTATUS_UXL    = 64'h0000_0002_0000_0000;
	localparam logic [11:0]     MIX_MASK       = 12'h999;
	localparam logic [XLEN-1:0] ALIGN4_MASK    = 64'hffff_ffff_ffff_fffc;
	localparam logic [XLEN-1:0] MTVEC_VEC_MASK = 64'hffff_ffff_ffff_ff01;
	localparam logic [XLEN-1:0] MCAUSE_MASK    = 64'h8000_0000_0000_000f;
	localparam logic [XLEN-1:0] MIMPID_VALUE   = 64'h2018_0200_0000_0000;
	localparam logic [XLEN-1:0] MISA_RESET     = 64'h8000_0000_0010_0100;

	typedef struct packed {
		logic            operation;
		logic [11:0]     csr_address;
		logic [XLEN-1:0] write_data;
	} csr_req_t;

	typedef struct packed {
		logic [XLEN-1:0] read_data;
		logic [1:0]      status;
	} csr_rsp_t;

endpackage

// ----- sv/machine_csr_file.sv -----
// Top level of the machine-mode CSR file: request register, decode and
// legalize logic, CSR storage and the result register.
// Depends on mcsr_pkg.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_stall | csr_req_t: op, address, data
//  out     | output    | out_valid/out_stall | csr_rsp_t: read data, status
//  cfg     | input     | cfg_valid/cfg_ready | 64-bit misa value
//
// One access per cycle is sustained while out does not stall. A beat is taken into the
// request register, then decode and legalize load the result register, from which the
// result leaves. The CSR write lands in the same edge that loads the result, so
// back-to-back accesses see each other in order.
// Reset clears valids and CSRs; misa returns to its RV64IU encoding.
// A stall on out holds the result register; the request register then
// fills and in_stall rises until the result is taken.
module machine_csr_file (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mcsr_pkg::csr_req_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mcsr_pkg::csr_rsp_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [63:0]        cfg_data
);
	import mcsr_pkg::*;

	// request stage
	logic     valid_s1;
	csr_req_t req_s1;

	// result stage
	logic     valid_s2;
	csr_rsp_t rsp_s2;

	// handshake control
	logic in_take;
	logic load_s2;
	logic advance;

	// CSR storage
	logic [XLEN-1:0] misa_q;
	logic [12:0]     mstatus_q;
	logic [11:0]     mie_q;
	logic [11:0]     mip_q;
	logic [XLEN-1:0] mtvec_q;
	logic [XLEN-1:0] mscratch_q;
	logic [XLEN-1:0] mepc_q;
	logic [XLEN-1:0] mcause_q;
	logic [XLEN-1:0] mtval_q;

	// decode results
	logic            is_write;
	logic [XLEN-1:0] wdata;
	logic [XLEN-1:0] rdata;
	logic [1:0]      status;
	logic [12:0]     mstatus_new;
	logic [11:0]     mix_new;
	logic [XLEN-1:0] mtvec_new;
	logic [XLEN-1:0] mepc_new;
	logic [XLEN-1:0] mcause_new;
	logic            we_mstatus;
	logic            we_mie;
	logic            we_mip;
	logic            we_mtvec;
	logic            we_mscratch;
	logic            we_mepc;
	logic            we_mcause;
	logic            we_mtval;

	// The result register loads when empty or when its beat leaves this cycle.
	assign load_s2   = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && load_s2;
	assign in_stall  = valid_s1 && !load_s2;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = valid_s2;
	assign out_data  = rsp_s2;

	// Request register: take a new beat when empty or when the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= in_data;
		end
	end

	// Legalized write values, one per register kind.
	assign is_write    = (req_s1.operation == OP_WRITE);
	assign wdata       = req_s1.write_data;
	assign mstatus_new = wdata[12:0] & MSTATUS_MASK;
	assign mix_new     = wdata[11:0] & MIX_MASK;
	assign mtvec_new   = wdata[0] ? (wdata & MTVEC_VEC_MASK) : (wdata & ALIGN4_MASK);
	assign mepc_new    = wdata & ALIGN4_MASK;
	assign mcause_new  = wdata & MCAUSE_MASK;

	// Address decode: pick the read value and status; a write returns
	// the value it leaves stored.
	always_comb begin
		rdata       = '0;
		status      = STATUS_OK;
		we_mstatus  = 1'b0;
		we_mie      = 1'b0;
		we_mip      = 1'b0;
		we_mtvec    = 1'b0;
		we_mscratch = 1'b0;
		we_mepc     = 1'b0;
		we_mcause   = 1'b0;
		we_mtval    = 1'b0;
		case (req_s1.csr_address)
			CSR_MSTATUS: begin
				we_mstatus = is_write;
				rdata = {51'b0, (is_write ? mstatus_new : mstatus_q)} | MSTATUS_UXL;
			end
			CSR_MISA: begin
				rdata = misa_q;
			end
			CSR_MIE: begin
				we_mie = is_write;
				rdata  = {52'b0, (is_write ? mix_new : mie_q)};
			end
			CSR_MTVEC: begin
				we_mtvec = is_write;
				rdata    = is_write ? mtvec_new : mtvec_q;
			end
			CSR_MSCRATCH: begin
				we_mscratch = is_write;
				rdata       = is_write ? wdata : mscratch_q;
			end
			CSR_MEPC: begin
				we_mepc = is_write;
				rdata   = is_write ? mepc_new : mepc_q;
			end
			CSR_MCAUSE: begin
				we_mcause = is_write;
				rdata     = is_write ? mcause_new : mcause_q;
			end
			CSR_MTVAL: begin
				we_mtval = is_write;
				rdata    = is_write ? wdata : mtval_q;
			end
			CSR_MIP: begin
				we_mip = is_write;
				rdata  = {52'b0, (is_write ? mix_new : mip_q)};
			end
			CSR_MVENDORID, CSR_MARCHID, CSR_MHARTID: begin
				rdata  = '0;
				status = is_write ? STATUS_READONLY : STATUS_OK;
			end
			CSR_MIMPID: begin
				rdata  = MIMPID_VALUE;
				status = is_write ? STATUS_READONLY : STATUS_OK;
			end
			default: begin
				rdata  = '0;
				status = STATUS_UNDEF;
			end
		endcase
	end

	// Result register: hold while stalled, drop the valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.read_data <= rdata;
			rsp_s2.status    <= status;
		end
	end

	// misa is written only over the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misa_q <= MISA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			misa_q <= cfg_data;
		end
	end

	// CSR storage: commit writes as the beat advances into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstatus_q  <= '0;
			mie_q      <= '0;
			mip_q      <= '0;
			mtvec_q    <= '0;
			mscratch_q <= '0;
			mepc_q     <= '0;
			mcause_q   <= '0;
			mtval_q    <= '0;
		end else if (advance) begin
			if (we_mstatus)  mstatus_q  <= mstatus_new;
			if (we_mie)      mie_q      <= mix_new;
			if (we_mip)      mip_q      <= mix_new;
			if (we_mtvec)    mtvec_q    <= mtvec_new;
			if (we_mscratch) mscratch_q <= wdata;
			if (we_mepc)     mepc_q     <= mepc_new;
			if (we_mcause)   mcause_q   <= mcause_new;
			if (we_mtval)    mtval_q    <= wdata;
		end
	end

`ifndef ASSERT_OFF
	// A stall on in only arises from a full request register.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty request register");

	// Stored mstatus and mcause never hold bits outside their masks.
	a_mstatus_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(mstatus_q & ~MSTATUS_MASK) == 13'd0)
		else $error("mstatus holds illegal bits");

	a_mcause_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(mcause_q & ~MCAUSE_MASK) == '0)
		else $error("mcause holds illegal bits");

	// A read-only result only comes from an ID register constant.
	a_readonly_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == STATUS_READONLY) |->
		(out_data.read_data == '0 || out_data.read_data == MIMPID_VALUE))
		else $error("read-only status with non-ID value");

	// A CSR write commits only while a beat moves into the result register; mepc is checked.
	a_write_with_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mepc_q) |-> $past(advance))
		else $error("mepc changed without an advancing beat");
`endif

endmodule
